/* rtl/hsvrgb_pkg.sv */
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Shared widths, scale constants, reciprocals and sector codes for the
// HSV to RGB pipeline.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

	// field widths
	localparam int HUE_W  = 10;
	localparam int CH_W   = 8;
	localparam int SEC_W  = 4;
	localparam int FRAC_W = 7;
	localparam int NUM_W  = 15;   // 30600 - s*part, at most 30600
	localparam int PRQ_W  = 23;   // v * num, at most 7,803,000
	localparam int PRP_W  = 16;   // v * (255 - s), at most 65025

	// scale constants
	localparam int SECTOR_SPAN = 120;
	localparam int UNIT_SCALE  = 255;
	localparam int FULL_SCALE  = 30600;

	// floor(2^32 / 30600) and floor(2^24 / 255); the estimate is low by at most one
	localparam int RECIP_FULL_W  = 18;
	localparam int RECIP_FULL_SH = 32;
	localparam logic [RECIP_FULL_W-1:0] RECIP_FULL = 18'd140358;
	localparam int RECIP_UNIT_W  = 17;
	localparam int RECIP_UNIT_SH = 24;
	localparam logic [RECIP_UNIT_W-1:0] RECIP_UNIT = 17'd65793;

	// hue sectors; anything above magenta-red is handled as magenta-red
	localparam logic [SEC_W-1:0] SEC_RED_YEL  = 4'd0;
	localparam logic [SEC_W-1:0] SEC_YEL_GRN  = 4'd1;
	localparam logic [SEC_W-1:0] SEC_GRN_CYN  = 4'd2;
	localparam logic [SEC_W-1:0] SEC_CYN_BLU  = 4'd3;
	localparam logic [SEC_W-1:0] SEC_BLU_MAG  = 4'd4;

	// data riding alongside the divider stages
	typedef struct packed {
		logic [SEC_W-1:0] sector;
		logic [CH_W-1:0]  v;
	} side_t;

endpackage

/* rtl/hsvrgb_div.sv */
// ----------------------------------------------------------------------------
// hsvrgb_div
// Two-stage constant divider: floor(xp/255), floor(xq/30600), floor(xt/30600)
// by reciprocal multiply followed by a single compare-and-increment fix-up.
// ----------------------------------------------------------------------------
module hsvrgb_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [hsvrgb_pkg::PRP_W-1:0]  xp,
	input  logic [hsvrgb_pkg::PRQ_W-1:0]  xq,
	input  logic [hsvrgb_pkg::PRQ_W-1:0]  xt,
	output logic                          out_valid,
	output logic [hsvrgb_pkg::CH_W-1:0]   level_p,
	output logic [hsvrgb_pkg::CH_W-1:0]   level_q,
	output logic [hsvrgb_pkg::CH_W-1:0]   level_t
);

	localparam int PW = hsvrgb_pkg::PRP_W + hsvrgb_pkg::RECIP_UNIT_W;
	localparam int QW = hsvrgb_pkg::PRQ_W + hsvrgb_pkg::RECIP_FULL_W;
	localparam int CW = hsvrgb_pkg::CH_W;

	logic [PW-1:0] est_p;
	logic [QW-1:0] est_q, est_t;

	logic                          valid_s4;
	logic [hsvrgb_pkg::PRP_W-1:0]  xp_s4;
	logic [hsvrgb_pkg::PRQ_W-1:0]  xq_s4, xt_s4;
	logic [CW-1:0]                 qp_s4, qq_s4, qt_s4;

	logic [hsvrgb_pkg::PRP_W-1:0]  rem_p;
	logic [hsvrgb_pkg::PRQ_W-1:0]  rem_q, rem_t;

	logic                          valid_s5;
	logic [CW-1:0]                 lp_s5, lq_s5, lt_s5;

	// quotient estimates
	assign est_p = PW'(xp) * PW'(hsvrgb_pkg::RECIP_UNIT);
	assign est_q = QW'(xq) * QW'(hsvrgb_pkg::RECIP_FULL);
	assign est_t = QW'(xt) * QW'(hsvrgb_pkg::RECIP_FULL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s4 <= in_valid;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		xp_s4 <= xp;
		xq_s4 <= xq;
		xt_s4 <= xt;
		qp_s4 <= est_p[hsvrgb_pkg::RECIP_UNIT_SH +: CW];
		qq_s4 <= est_q[hsvrgb_pkg::RECIP_FULL_SH +: CW];
		qt_s4 <= est_t[hsvrgb_pkg::RECIP_FULL_SH +: CW];
	end

	// remainders; each is below twice the divisor
	assign rem_p = xp_s4 - hsvrgb_pkg::PRP_W'(qp_s4) *
		hsvrgb_pkg::PRP_W'(hsvrgb_pkg::UNIT_SCALE);
	assign rem_q = xq_s4 - hsvrgb_pkg::PRQ_W'(qq_s4) *
		hsvrgb_pkg::PRQ_W'(hsvrgb_pkg::FULL_SCALE);
	assign rem_t = xt_s4 - hsvrgb_pkg::PRQ_W'(qt_s4) *
		hsvrgb_pkg::PRQ_W'(hsvrgb_pkg::FULL_SCALE);

	// fix-up: bump the estimate when a whole divisor is left over
	always_ff @(posedge clk) begin
		lp_s5 <= (rem_p >= hsvrgb_pkg::PRP_W'(hsvrgb_pkg::UNIT_SCALE)) ?
			qp_s4 + 8'd1 : qp_s4;
		lq_s5 <= (rem_q >= hsvrgb_pkg::PRQ_W'(hsvrgb_pkg::FULL_SCALE)) ?
			qq_s4 + 8'd1 : qq_s4;
		lt_s5 <= (rem_t >= hsvrgb_pkg::PRQ_W'(hsvrgb_pkg::FULL_SCALE)) ?
			qt_s4 + 8'd1 : qt_s4;
	end

	assign out_valid = valid_s5;
	assign level_p   = lp_s5;
	assign level_q   = lq_s5;
	assign level_t   = lt_s5;

endmodule

/* rtl/hsv_to_rgb.sv */
// ----------------------------------------------------------------------------
// hsv_to_rgb
// Throughput: one request per clock; six register stages, the slowest being
// the 23x18 reciprocal multiply in the divider. busy is always low.
// Reset: arst_n clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module hsv_to_rgb (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [hsvrgb_pkg::HUE_W-1:0]  hue,
	input  logic [hsvrgb_pkg::CH_W-1:0]   saturation,
	input  logic [hsvrgb_pkg::CH_W-1:0]   brightness,
	output logic                          done,
	output logic [hsvrgb_pkg::CH_W-1:0]   red,
	output logic [hsvrgb_pkg::CH_W-1:0]   green,
	output logic [hsvrgb_pkg::CH_W-1:0]   blue
);

	localparam int HW = hsvrgb_pkg::HUE_W;
	localparam int CW = hsvrgb_pkg::CH_W;
	localparam int SW = hsvrgb_pkg::SEC_W;
	localparam int FW = hsvrgb_pkg::FRAC_W;
	localparam int NW = hsvrgb_pkg::NUM_W;

	logic accept;

	logic [SW-1:0] sec_c;
	logic [FW-1:0] frac_c;

	logic          valid_s1, valid_s2, valid_s3, valid_s6;
	logic [SW-1:0] sec_s1;
	logic [FW-1:0] frac_s1;
	logic [CW-1:0] s_s1, v_s1;

	logic [FW-1:0] part_t;
	hsvrgb_pkg::side_t side_s2, side_s3, side_s4, side_s5;
	logic [NW-1:0] numq_s2, numt_s2;
	logic [CW-1:0] inv_s_s2;
	logic [CW-1:0] v_s2;

	logic [hsvrgb_pkg::PRP_W-1:0] xp_s3;
	logic [hsvrgb_pkg::PRQ_W-1:0] xq_s3, xt_s3;

	logic          div_valid;
	logic [CW-1:0] lvl_p, lvl_q, lvl_t;

	logic [CW-1:0] red_s6, green_s6, blue_s6;

	// the pipeline never stalls
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// sector and fraction: count crossed multiples of 120, then subtract
	always_comb begin
		sec_c = '0;
		for (int k = 1; k <= 8; k++) begin
			if (hue >= HW'(k * hsvrgb_pkg::SECTOR_SPAN))
				sec_c = sec_c + 4'd1;
		end
		frac_c = FW'(hue - HW'(32'(sec_c) * hsvrgb_pkg::SECTOR_SPAN));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s6 <= div_valid;
		end
	end

	// stage 1: split hue
	always_ff @(posedge clk) begin
		sec_s1  <= sec_c;
		frac_s1 <= frac_c;
		s_s1    <= saturation;
		v_s1    <= brightness;
	end

	// stage 2: numerators 30600 - s*part and 255 - s
	assign part_t = FW'(hsvrgb_pkg::SECTOR_SPAN) - frac_s1;

	always_ff @(posedge clk) begin
		numq_s2  <= NW'(hsvrgb_pkg::FULL_SCALE) - NW'(s_s1) * NW'(frac_s1);
		numt_s2  <= NW'(hsvrgb_pkg::FULL_SCALE) - NW'(s_s1) * NW'(part_t);
		inv_s_s2 <= CW'(hsvrgb_pkg::UNIT_SCALE) - s_s1;
		v_s2     <= v_s1;
		side_s2  <= '{sector: sec_s1, v: v_s1};
	end

	// stage 3: scale by value
	always_ff @(posedge clk) begin
		xp_s3   <= hsvrgb_pkg::PRP_W'(v_s2) * hsvrgb_pkg::PRP_W'(inv_s_s2);
		xq_s3   <= hsvrgb_pkg::PRQ_W'(v_s2) * hsvrgb_pkg::PRQ_W'(numq_s2);
		xt_s3   <= hsvrgb_pkg::PRQ_W'(v_s2) * hsvrgb_pkg::PRQ_W'(numt_s2);
		side_s3 <= side_s2;
	end

	// stages 4 and 5: constant division
	hsvrgb_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s3),
		.xp        (xp_s3),
		.xq        (xq_s3),
		.xt        (xt_s3),
		.out_valid (div_valid),
		.level_p   (lvl_p),
		.level_q   (lvl_q),
		.level_t   (lvl_t)
	);

	// side data kept in step with the divider
	always_ff @(posedge clk) begin
		side_s4 <= side_s3;
		side_s5 <= side_s4;
	end

	// stage 6: sector table
	always_ff @(posedge clk) begin
		unique case (side_s5.sector)
			hsvrgb_pkg::SEC_RED_YEL: begin
				red_s6 <= side_s5.v; green_s6 <= lvl_t; blue_s6 <= lvl_p;
			end
			hsvrgb_pkg::SEC_YEL_GRN: begin
				red_s6 <= lvl_q; green_s6 <= side_s5.v; blue_s6 <= lvl_p;
			end
			hsvrgb_pkg::SEC_GRN_CYN: begin
				red_s6 <= lvl_p; green_s6 <= side_s5.v; blue_s6 <= lvl_t;
			end
			hsvrgb_pkg::SEC_CYN_BLU: begin
				red_s6 <= lvl_p; green_s6 <= lvl_q; blue_s6 <= side_s5.v;
			end
			hsvrgb_pkg::SEC_BLU_MAG: begin
				red_s6 <= lvl_t; green_s6 <= lvl_p; blue_s6 <= side_s5.v;
			end
			default: begin
				red_s6 <= side_s5.v; green_s6 <= lvl_p; blue_s6 <= lvl_q;
			end
		endcase
	end

	assign done  = valid_s6;
	assign red   = red_s6;
	assign green = green_s6;
	assign blue  = blue_s6;

	// every accepted request comes out as a done strobe
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##6 done)
		else $error("request not completed after six cycles");

	// no channel exceeds the value it came from
	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (red <= $past(brightness, 6)) && (green <= $past(brightness, 6)) &&
			(blue <= $past(brightness, 6)))
		else $error("channel above brightness");

	// the largest channel equals the value
	a_peak: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (red == $past(brightness, 6)) || (green == $past(brightness, 6)) ||
			(blue == $past(brightness, 6)))
		else $error("no channel carries brightness");

	// zero saturation gives gray
	a_gray: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ($past(saturation, 6) == '0)) |->
			(red == $past(brightness, 6)) && (green == $past(brightness, 6)) &&
			(blue == $past(brightness, 6)))
		else $error("zero saturation not gray");

endmodule

/* test/tb_hsv_to_rgb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hsv_to_rgb
// Self-checking bench for the HSV to RGB converter. A clocked driver feeds
// requests from a backlog queue and predicts each color as it is accepted.
// A clocked monitor checks every done strobe against the oldest prediction.
// The run has directed corner cases, then random requests in four idling
// phases. Each phase first lets the pipeline drain empty.
// ----------------------------------------------------------------------------
module tb_hsv_to_rgb;

	localparam int HW = hsvrgb_pkg::HUE_W;
	localparam int CW = hsvrgb_pkg::CH_W;
	localparam int SW = hsvrgb_pkg::SEC_W;

	localparam int STALL_LIMIT  = 2000;  // cycles with no request and no result
	localparam int DRAIN_CYCLES = 12;    // pipeline is 6 deep
	localparam int PHASE_ITEMS  = 257;
	localparam int MAX_REPORTS  = 10;

	typedef struct packed {
		logic [HW-1:0] hue;
		logic [CW-1:0] sat;
		logic [CW-1:0] val;
		logic [6:0]    idle_pct;  // chance the sender idles in a cycle
		logic          drain;     // hold until every result is back
	} hsv_req_t;

	typedef struct packed {
		logic [CW-1:0] red;
		logic [CW-1:0] green;
		logic [CW-1:0] blue;
	} rgb_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [HW-1:0] hue = '0;
	logic [CW-1:0] saturation = '0;
	logic [CW-1:0] brightness = '0;
	logic done;
	logic [CW-1:0] red;
	logic [CW-1:0] green;
	logic [CW-1:0] blue;

	hsv_req_t hsv_backlog[$];
	rgb_t rgb_due[$];

	int sent_count = 0;
	int checked_count = 0;
	int mismatch_count = 0;
	int gray_count = 0;
	int wide_hue_count = 0;
	int stall_cycles = 0;

	hsv_to_rgb dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.hue       (hue),
		.saturation(saturation),
		.brightness(brightness),
		.done      (done),
		.red       (red),
		.green     (green),
		.blue      (blue)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// floor(v * (30600 - s*part) / 30600)
	function automatic int unsigned shade_level(int unsigned v, int unsigned s,
			int unsigned part);
		return (v * (hsvrgb_pkg::FULL_SCALE - s * part)) / hsvrgb_pkg::FULL_SCALE;
	endfunction

	function automatic rgb_t convert_hsv(logic [HW-1:0] h, logic [CW-1:0] s,
			logic [CW-1:0] v);
		int unsigned hh, ss, vv, frac, p, q, t;
		logic [SW-1:0] sector;
		rgb_t c;
		hh = h;
		ss = s;
		vv = v;
		sector = SW'(hh / hsvrgb_pkg::SECTOR_SPAN);
		frac = hh % hsvrgb_pkg::SECTOR_SPAN;
		p = (vv * (hsvrgb_pkg::UNIT_SCALE - ss)) / hsvrgb_pkg::UNIT_SCALE;
		q = shade_level(vv, ss, frac);
		t = shade_level(vv, ss, hsvrgb_pkg::SECTOR_SPAN - frac);
		// hues past 719 fall into the last sector
		case (sector)
			hsvrgb_pkg::SEC_RED_YEL: c = '{CW'(vv), CW'(t), CW'(p)};
			hsvrgb_pkg::SEC_YEL_GRN: c = '{CW'(q), CW'(vv), CW'(p)};
			hsvrgb_pkg::SEC_GRN_CYN: c = '{CW'(p), CW'(vv), CW'(t)};
			hsvrgb_pkg::SEC_CYN_BLU: c = '{CW'(p), CW'(q), CW'(vv)};
			hsvrgb_pkg::SEC_BLU_MAG: c = '{CW'(t), CW'(p), CW'(vv)};
			default:                 c = '{CW'(vv), CW'(p), CW'(q)};
		endcase
		return c;
	endfunction

	task automatic add_req(int h, int s, int v, int idle_pct, bit drain);
		hsv_req_t r;
		r.hue = HW'(h);
		r.sat = CW'(s);
		r.val = CW'(v);
		r.idle_pct = 7'(idle_pct);
		r.drain = drain;
		hsv_backlog.push_back(r);
	endtask

	function automatic int pick_level();
		if ($urandom_range(9) == 0)
			return $urandom_range(1) ? 255 : 0;
		return $urandom_range(255);
	endfunction

	// Driver: predict on acceptance, then maybe present the next request
	always @(posedge clk) begin : drive
		logic go;
		hsv_req_t nxt;
		go = start;
		if (arst_n) begin
			if (start && !busy) begin
				rgb_due.push_back(convert_hsv(hue, saturation, brightness));
				sent_count++;
				if (saturation == 0)
					gray_count++;
				if (hue >= 720)
					wide_hue_count++;
				go = 1'b0;
			end
			if (!go && hsv_backlog.size() > 0) begin
				nxt = hsv_backlog[0];
				if (!(nxt.drain && rgb_due.size() > 0) &&
						$urandom_range(99) >= nxt.idle_pct) begin
					void'(hsv_backlog.pop_front());
					hue <= nxt.hue;
					saturation <= nxt.sat;
					brightness <= nxt.val;
					go = 1'b1;
				end
			end
			start <= go;
		end
	end

	// Monitor: every done strobe must match the oldest prediction
	always @(posedge clk) begin : watch
		rgb_t want;
		if (arst_n && done) begin
			if (rgb_due.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected result: rgb %0d %0d %0d", red, green, blue);
			end else begin
				want = rgb_due.pop_front();
				checked_count++;
				if (red !== want.red || green !== want.green || blue !== want.blue) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("mismatch #%0d: expected rgb %0d %0d %0d, got %0d %0d %0d",
							checked_count, want.red, want.green, want.blue,
							red, green, blue);
				end
			end
		end
	end

	// Watchdog: give up when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("watchdog: no activity for %0d cycles", STALL_LIMIT);
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		int idle_pct;
		// directed: sector edges, gray, black, hues past 719, bit patterns
		add_req(0, 0, 0, 0, 1'b0);
		add_req(0, 255, 255, 0, 1'b0);
		add_req(119, 255, 255, 0, 1'b0);
		add_req(120, 255, 255, 0, 1'b0);
		add_req(239, 200, 180, 0, 1'b0);
		add_req(240, 255, 255, 0, 1'b0);
		add_req(359, 128, 77, 0, 1'b0);
		add_req(360, 255, 255, 0, 1'b0);
		add_req(479, 255, 254, 0, 1'b0);
		add_req(480, 255, 255, 0, 1'b0);
		add_req(599, 1, 255, 0, 1'b0);
		add_req(600, 255, 255, 0, 1'b0);
		add_req(719, 255, 255, 0, 1'b0);
		add_req(720, 255, 255, 0, 1'b0);
		add_req(839, 90, 200, 0, 1'b0);
		add_req(960, 170, 85, 0, 1'b0);
		add_req(1023, 255, 255, 0, 1'b0);
		add_req(300, 0, 200, 0, 1'b0);
		add_req(650, 0, 255, 0, 1'b0);
		add_req(60, 255, 0, 0, 1'b0);
		add_req(512, 85, 170, 0, 1'b0);
		add_req(341, 170, 85, 0, 1'b0);

		// random phases: no idling, sender idle 73%, receiver-only (no effect), both 25%
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				1:       idle_pct = 73;
				3:       idle_pct = 25;
				default: idle_pct = 0;
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++)
				add_req(($urandom_range(9) == 0) ? $urandom_range(1023, 720)
						: $urandom_range(719),
					pick_level(), pick_level(), idle_pct, i == 0);
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (hsv_backlog.size() > 0 || start)
			@(posedge clk);
		while (rgb_due.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (rgb_due.size() > 0) begin
			mismatch_count++;
			$display("%0d expected results never arrived", rgb_due.size());
		end
		$display("covered %0d requests (%0d gray, %0d hues past 719), %0d results checked",
			sent_count, gray_count, wide_hue_count, checked_count);
		$display("%0d mismatches over four idling phases", mismatch_count);
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

/* sim.f */
rtl/hsvrgb_pkg.sv
rtl/hsvrgb_div.sv
rtl/hsv_to_rgb.sv
test/tb_hsv_to_rgb.sv
